/* rtl/core/drift_tube_laterality_fit_assert.svh */
// ----------------------------------------------------------------------------
// drift tube laterality fit assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef DRIFT_TUBE_LATERALITY_FIT_ASSERT_SVH
`define DRIFT_TUBE_LATERALITY_FIT_ASSERT_SVH

// same-cycle implication
`define DTLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTLF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/dtlf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtlf_pkg
// shared types, widths and constants of the drift tube laterality fit
// ----------------------------------------------------------------------------
package dtlf_pkg;

  localparam int HITS_CAP  = 4;
  localparam int Y2_W      = 19;
  localparam int XW_W      = 22;
  localparam int D2_W      = 16;
  localparam int X_W       = 23;
  localparam int DIVD_W    = 64;
  localparam int DIVS_W    = 19;
  localparam int DIVC_W    = 7;
  localparam int SLOPE_W   = 31;
  localparam int SUM_W     = 34;
  localparam int QUAL_W    = 24;
  localparam int ROOT_W    = 32;
  localparam int QDEPTH    = 2;

  localparam logic [29:0]       SLOPE_LIM = 30'h2000_0000;
  localparam logic [QUAL_W-1:0] QUAL_MAX  = 24'hFF_FFFF;

  localparam logic [1:0] CFG_PITCH = 2'd0;
  localparam logic [1:0] CFG_WIDTH = 2'd1;
  localparam logic [1:0] CFG_PED   = 2'd2;
  localparam logic [1:0] CFG_VDRIFT = 2'd3;

  localparam logic [1:0] LAT_NONE  = 2'b00;
  localparam logic [1:0] LAT_RIGHT = 2'b01;
  localparam logic [1:0] LAT_LEFT  = 2'b11;

  typedef struct packed {
    logic [1:0]      layer;
    logic [Y2_W-1:0] y2;
    logic [XW_W-1:0] xw;
    logic [D2_W-1:0] d2;
    logic            onwire;
  } hit_t;

  typedef struct packed {
    hit_t [HITS_CAP-1:0] hits;
    logic [2:0]          n;
    logic                ovf;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SLOPE_GO, ST_SLOPE_WAIT, ST_SUM, ST_MEAN_GO, ST_MEAN_WAIT,
    ST_SQ, ST_VAR_GO, ST_VAR_WAIT, ST_SQRT, ST_PICK, ST_NEXT, ST_EMIT
  } back_state_t;

  // pair order keeps the pairs of the first three hits in front
  function automatic logic [1:0] pair_j(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      3'd0, 3'd1, 3'd3: r = 2'd0;
      3'd2, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_k(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      3'd0:       r = 2'd1;
      3'd1, 3'd2: r = 2'd2;
      default:    r = 2'd3;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/drift_tube_laterality_fit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Drift tube laterality fit. Hits of a cluster are taken one per cycle while
// the two-cluster queue has room; a whole cluster is then fitted by the back
// end. The fit time per cluster is set by one shared 64-step radix-2 divider
// and a 32-step square root, used for the pair slopes and then for each
// laterality combination (2^n of them). Clusters of fewer than three hits
// skip the fit and go straight to the result.
// Configuration is held in local registers and must be written
// only while no cluster is in flight.
// ----------------------------------------------------------------------------
// drift_tube_laterality_fit
// top level: configuration registers, hit front end, queue and fit engine
// ----------------------------------------------------------------------------
module drift_tube_laterality_fit #(
  parameter int MAX_HITS        = 4,
  parameter int CELLS_PER_LAYER = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         layer,
  input  wire logic [3:0]         cell_req,
  input  wire logic signed [14:0] hit_time,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [1:0]       lat_layer0,
  output logic signed [1:0]       lat_layer1,
  output logic signed [1:0]       lat_layer2,
  output logic signed [1:0]       lat_layer3,
  output logic [23:0]             quality,
  output logic                    valid_res,
  output logic                    overflow
);
  import dtlf_pkg::*;

  logic [15:0]        cell_pitch_y;
  logic [15:0]        cell_width;
  logic signed [14:0] time_pedestal;
  logic [11:0]        drift_velocity;

  logic q_push, q_full, q_pop, q_valid;
  rec_t push_rec, pop_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_pitch_y   <= 16'd13000;
      cell_width     <= 16'd42000;
      time_pedestal  <= '0;
      drift_velocity <= 12'd864;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PITCH:  cell_pitch_y   <= cfg_data;
        CFG_WIDTH:  cell_width     <= cfg_data;
        CFG_PED:    time_pedestal  <= cfg_data[14:0];
        CFG_VDRIFT: drift_velocity <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  dtlf_front #(
    .MAX_HITS        (MAX_HITS),
    .CELLS_PER_LAYER (CELLS_PER_LAYER)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cell_pitch_y   (cell_pitch_y),
    .cell_width     (cell_width),
    .time_pedestal  (time_pedestal),
    .drift_velocity (drift_velocity),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .layer          (layer),
    .cell_req       (cell_req),
    .hit_time       (hit_time),
    .last           (last),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (push_rec)
  );

  dtlf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (pop_rec)
  );

  dtlf_back #(
    .MAX_HITS (MAX_HITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (pop_rec),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .lat_layer0 (lat_layer0),
    .lat_layer1 (lat_layer1),
    .lat_layer2 (lat_layer2),
    .lat_layer3 (lat_layer3),
    .quality    (quality),
    .valid_res  (valid_res),
    .overflow   (overflow)
  );

endmodule
`default_nettype wire

/* rtl/core/dtlf_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtlf_div
// shared radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dtlf_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [dtlf_pkg::DIVD_W-1:0] dividend,
  input  wire logic [dtlf_pkg::DIVS_W-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic [dtlf_pkg::DIVD_W-1:0]      quotient
);
  import dtlf_pkg::*;

  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [DIVC_W-1:0] cnt;
  logic [DIVS_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem, quotient[DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIVC_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIVC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= fits ? DIVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIVS_W-1:0];
      quotient <= {quotient[DIVD_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/dtlf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtlf_front
// takes hits, works out their geometry and hands whole clusters to the queue
// ----------------------------------------------------------------------------
module dtlf_front #(
  parameter int MAX_HITS        = 4,
  parameter int CELLS_PER_LAYER = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [15:0]           cell_pitch_y,
  input  wire logic [15:0]           cell_width,
  input  wire logic signed [14:0]    time_pedestal,
  input  wire logic [11:0]           drift_velocity,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            layer,
  input  wire logic [3:0]            cell_req,
  input  wire logic signed [14:0]    hit_time,
  input  wire logic                  last,
  input  wire logic                  q_full,
  output logic                       q_push,
  output dtlf_pkg::rec_t             q_data
);
  import dtlf_pkg::*;

  hit_t [HITS_CAP-1:0] hbuf;
  logic [2:0]          hit_count;
  logic                ovf;

  logic              acc;
  logic              room;
  logic [3:0]        cell_c;
  logic [5:0]        fac_x;
  logic [15:0]       dt;
  logic [26:0]       dprod;
  logic [19:0]       dfull;
  hit_t              new_hit;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign room     = hit_count < 3'(MAX_HITS);
  assign q_push   = acc && last;

  always_comb begin
    cell_c = ({3'b0, cell_req} >= 7'(CELLS_PER_LAYER)) ? 4'(CELLS_PER_LAYER - 1) : cell_req;
    fac_x  = {1'b0, cell_c, 1'b0} + (layer[0] ? 6'd1 : 6'd2);
    dt     = 16'({hit_time[14], hit_time} - {time_pedestal[14], time_pedestal});
    dprod  = dt[14:0] * drift_velocity;
    dfull  = dprod[26:7];
    new_hit.layer  = layer;
    new_hit.y2     = {layer, 1'b1} * cell_pitch_y;
    new_hit.xw     = fac_x * cell_width;
    new_hit.onwire = dt[15];
    new_hit.d2     = (dfull < {4'b0, cell_width}) ? dfull[15:0] : cell_width;
  end

  always_comb begin
    for (int i = 0; i < HITS_CAP; i++) begin
      q_data.hits[i] = (room && hit_count == 3'(i)) ? new_hit : hbuf[i];
    end
    q_data.n   = room ? hit_count + 3'd1 : hit_count;
    q_data.ovf = ovf || !room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count <= '0;
      ovf       <= 1'b0;
    end else if (acc) begin
      hit_count <= last ? 3'd0 : q_data.n;
      ovf       <= last ? 1'b0 : q_data.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hbuf <= q_data.hits;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/dtlf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtlf_queue
// short cluster queue between the hit front end and the fit engine
// ----------------------------------------------------------------------------
module dtlf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  dtlf_pkg::rec_t      push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output dtlf_pkg::rec_t      pop_data
);
  import dtlf_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  rec_t             mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = count == (PTR_W+1)'(QDEPTH);
  assign valid    = count != '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/dtlf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "drift_tube_laterality_fit_assert.svh"
// ----------------------------------------------------------------------------
// dtlf_back
// fit engine: pair slopes, per-combination spread and best pick
// ----------------------------------------------------------------------------
module dtlf_back #(
  parameter int MAX_HITS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  dtlf_pkg::rec_t          q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [1:0]       lat_layer0,
  output logic signed [1:0]       lat_layer1,
  output logic signed [1:0]       lat_layer2,
  output logic signed [1:0]       lat_layer3,
  output logic [23:0]             quality,
  output logic                    valid_res,
  output logic                    overflow
);
  import dtlf_pkg::*;

  localparam int NPAIRS  = MAX_HITS * (MAX_HITS - 1) / 2;
  localparam int PIDX_W  = $clog2(NPAIRS + 1);
  localparam int PSEL_W  = $clog2(NPAIRS);
  localparam int COMBO_W = MAX_HITS + 1;

  back_state_t state, state_next;

  rec_t                        rec;
  logic [PIDX_W-1:0]           pidx;
  logic [1:0]                  vidx;
  logic signed [SLOPE_W-1:0]   slope [NPAIRS][4];
  logic [NPAIRS-1:0]           pair_ok;
  logic [COMBO_W-1:0]          combo;
  logic signed [SUM_W-1:0]     sum;
  logic [2:0]                  cnt;
  logic signed [SLOPE_W-1:0]   mean;
  logic [61:0]                 prod;
  logic [63:0]                 sq;
  logic [63:0]                 sv;
  logic [63:0]                 sr;
  logic [63:0]                 sbit;
  logic [ROOT_W-1:0]           best;
  logic [MAX_HITS-1:0]         best_combo;
  logic                        found;
  logic                        neg;

  logic                        div_start;
  logic                        div_busy;
  logic                        div_done;
  logic [DIVD_W-1:0]           div_dvd;
  logic [DIVS_W-1:0]           div_dvs;
  logic [DIVD_W-1:0]           div_q;
  logic                        load_out;

  logic [PSEL_W-1:0]           psel;
  logic [1:0]                  pj, pk;
  hit_t                        hj, hk;
  logic [X_W-1:0]              xj, xk;
  logic signed [X_W:0]         dx;
  logic signed [Y2_W:0]        dy;
  logic [X_W-1:0]              absdx;
  logic [Y2_W-1:0]             absdy;
  logic                        pair_live;
  logic [29:0]                 qsat;
  logic signed [SLOPE_W-1:0]   slope_val;
  logic [MAX_HITS-1:0]         combo_lo;
  logic signed [SLOPE_W-1:0]   cs;
  logic [SUM_W-2:0]            abssum;
  logic signed [SLOPE_W:0]     dv;
  logic [SLOPE_W-1:0]          adv;
  logic [63:0]                 trial;
  logic [COMBO_W-1:0]          combo_end;
  logic [1:0]                  lat_arr [4];
  logic [QUAL_W-1:0]           qual_val;

  function automatic logic [X_W-1:0] hit_x(input hit_t h, input logic right);
    logic [X_W-1:0] base;
    logic [X_W-1:0] d;
    base = {1'b0, h.xw};
    d    = X_W'(h.d2);
    if (h.onwire) return base;
    return right ? base + d : base - d;
  endfunction

  dtlf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // datapath views of the current pair and combination
  always_comb begin
    psel      = pidx[PSEL_W-1:0];
    pj        = pair_j(3'(pidx));
    pk        = pair_k(3'(pidx));
    hj        = rec.hits[pj];
    hk        = rec.hits[pk];
    xj        = hit_x(hj, vidx[0]);
    xk        = hit_x(hk, vidx[1]);
    dx        = $signed({1'b0, xj}) - $signed({1'b0, xk});
    dy        = $signed({1'b0, hj.y2}) - $signed({1'b0, hk.y2});
    absdx     = dx[X_W] ? X_W'(-dx) : dx[X_W-1:0];
    absdy     = dy[Y2_W] ? Y2_W'(-dy) : dy[Y2_W-1:0];
    pair_live = ({1'b0, pk} < rec.n) && (dy != '0);
    qsat      = (div_q > DIVD_W'(SLOPE_LIM)) ? SLOPE_LIM : div_q[29:0];
    slope_val = neg ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
    combo_lo  = combo[MAX_HITS-1:0];
    cs        = (pidx < PIDX_W'(NPAIRS)) ? slope[psel][{combo_lo[pk], combo_lo[pj]}] : '0;
    abssum    = sum[SUM_W-1] ? (SUM_W-1)'(-sum) : sum[SUM_W-2:0];
    dv        = $signed({cs[SLOPE_W-1], cs}) - $signed({mean[SLOPE_W-1], mean});
    adv       = dv[SLOPE_W] ? SLOPE_W'(-dv) : dv[SLOPE_W-1:0];
    trial     = sr + sbit;
    combo_end = COMBO_W'(1) << rec.n;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = (q_data.n < 3'd3) ? ST_EMIT : ST_SLOPE_GO;
        end
      end
      ST_SLOPE_GO: begin
        if (pidx == PIDX_W'(NPAIRS)) begin
          state_next = ST_SUM;
        end else if (pair_live) begin
          div_start  = 1'b1;
          div_dvd    = DIVD_W'({absdx, 16'b0});
          div_dvs    = absdy;
          state_next = ST_SLOPE_WAIT;
        end
      end
      ST_SLOPE_WAIT: if (div_done) state_next = ST_SLOPE_GO;
      ST_SUM: begin
        if (pidx == PIDX_W'(NPAIRS)) state_next = (cnt < 3'd2) ? ST_NEXT : ST_MEAN_GO;
      end
      ST_MEAN_GO: begin
        div_start  = 1'b1;
        div_dvd    = DIVD_W'(abssum);
        div_dvs    = DIVS_W'(cnt);
        state_next = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: if (div_done) state_next = ST_SQ;
      ST_SQ: if (pidx == PIDX_W'(NPAIRS)) state_next = ST_VAR_GO;
      ST_VAR_GO: begin
        div_start  = 1'b1;
        div_dvd    = sq;
        div_dvs    = DIVS_W'(cnt - 3'd1);
        state_next = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: if (div_done) state_next = ST_SQRT;
      ST_SQRT: if (sbit == '0) state_next = ST_PICK;
      ST_PICK: state_next = ST_NEXT;
      ST_NEXT: state_next = (combo + 1'b1 == combo_end) ? ST_EMIT : ST_SUM;
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          rec     <= q_data;
          pidx    <= '0;
          vidx    <= '0;
          pair_ok <= '0;
        end
      end
      ST_SLOPE_GO: begin
        if (pidx == PIDX_W'(NPAIRS)) begin
          pidx  <= '0;
          combo <= '0;
          sum   <= '0;
          cnt   <= '0;
        end else if (pair_live) begin
          neg <= dx[X_W] ^ dy[Y2_W];
        end else begin
          pidx <= pidx + 1'b1;
          vidx <= '0;
        end
      end
      ST_SLOPE_WAIT: begin
        if (div_done) begin
          slope[psel][vidx] <= slope_val;
          pair_ok[psel]     <= 1'b1;
          vidx              <= vidx + 1'b1;
          if (vidx == 2'd3) pidx <= pidx + 1'b1;
        end
      end
      ST_SUM: begin
        if (pidx != PIDX_W'(NPAIRS)) begin
          if (pair_ok[psel]) begin
            sum <= sum + SUM_W'(cs);
            cnt <= cnt + 3'd1;
          end
          pidx <= pidx + 1'b1;
        end else begin
          neg  <= sum[SUM_W-1];
          pidx <= '0;
          prod <= '0;
          sq   <= '0;
        end
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          mean <= neg ? -$signed({1'b0, div_q[29:0]}) : $signed({1'b0, div_q[29:0]});
        end
      end
      ST_SQ: begin
        // product is registered, the add follows in the next cycle
        sq <= sq + 64'(prod);
        if (pidx != PIDX_W'(NPAIRS)) begin
          prod <= pair_ok[psel] ? adv * adv : '0;
          pidx <= pidx + 1'b1;
        end
      end
      ST_VAR_WAIT: begin
        if (div_done) begin
          sv   <= div_q;
          sr   <= '0;
          sbit <= 64'h4000_0000_0000_0000;
        end
      end
      ST_SQRT: begin
        if (sbit != '0) begin
          if (sv >= trial) begin
            sv <= sv - trial;
            sr <= (sr >> 1) + sbit;
          end else begin
            sr <= sr >> 1;
          end
          sbit <= sbit >> 2;
        end
      end
      ST_PICK: begin
        if (!found || sr[ROOT_W-1:0] < best) begin
          best       <= sr[ROOT_W-1:0];
          best_combo <= combo_lo;
        end
      end
      ST_NEXT: begin
        combo <= combo + 1'b1;
        sum   <= '0;
        cnt   <= '0;
        pidx  <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (state == ST_IDLE) begin
      found <= 1'b0;
    end else if (state == ST_PICK) begin
      found <= 1'b1;
    end
  end

  // later hits win their layer
  always_comb begin
    for (int l = 0; l < 4; l++) lat_arr[l] = LAT_NONE;
    if (rec.n >= 3'd3 && found) begin
      for (int j = 0; j < MAX_HITS; j++) begin
        if (3'(j) < rec.n) begin
          lat_arr[rec.hits[j].layer] = rec.hits[j].onwire ? LAT_NONE :
                                       (best_combo[j] ? LAT_RIGHT : LAT_LEFT);
        end
      end
    end
    if (rec.n < 3'd3)                 qual_val = '0;
    else if (!found)                  qual_val = QUAL_MAX;
    else if (best > ROOT_W'(QUAL_MAX)) qual_val = QUAL_MAX;
    else                              qual_val = best[QUAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      lat_layer0 <= lat_arr[0];
      lat_layer1 <= lat_arr[1];
      lat_layer2 <= lat_arr[2];
      lat_layer3 <= lat_arr[3];
      quality    <= qual_val;
      valid_res  <= rec.n >= 3'd3;
      overflow   <= rec.ovf;
    end
  end

  `DTLF_ASSERT_IMP(a_pop_needs_data, q_pop, q_valid, "queue popped while empty")
  `DTLF_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider started while busy")
  `DTLF_ASSERT_IMP(a_root_bit, state == ST_SQRT, $onehot0(sbit), "root bit not one-hot")
  `DTLF_ASSERT_NXT(a_short_clean, load_out && rec.n < 3'd3,
                   quality == '0 && !valid_res && lat_layer0 == LAT_NONE,
                   "short cluster gave a non-empty result")

endmodule
`default_nettype wire

/* sim/drift_tube_laterality_fit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drift_tube_laterality_fit_checker
// watches the config port and both channels, predicts the best laterality of
// each cluster and compares every result item with the oldest prediction
// ----------------------------------------------------------------------------
module drift_tube_laterality_fit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         layer,
  input  logic [3:0]         cell_req,
  input  logic signed [14:0] hit_time,
  input  logic               last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [1:0]  lat_layer0,
  input  logic signed [1:0]  lat_layer1,
  input  logic signed [1:0]  lat_layer2,
  input  logic signed [1:0]  lat_layer3,
  input  logic [23:0]        quality,
  input  logic               valid_res,
  input  logic               overflow,
  output int                 fails,
  output int                 pending
);
  import dtlf_pkg::*;

  typedef struct {
    logic [1:0]  lat [4];
    logic [23:0] qual;
    logic        vld;
    logic        ovf;
  } fit_result_t;

  fit_result_t fit_queue[$];

  longint unsigned pitch_y, width_x, vdrift;
  longint          pedestal;
  logic [1:0]      hit_lyr [4];
  logic [3:0]      hit_cell [4];
  longint          hit_tm [4];
  int              nhits;
  logic            ovf_seen;

  assign pending = fit_queue.size();

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic fit_result_t predict_fit();
    fit_result_t res;
    longint y2 [4], xw [4], d2 [4], x [4], s [16];
    bit onwire [4];
    int lats [4], best_lats [4];
    longint dt, d, dy, v, sum, mean, dv;
    longint unsigned sq, sd, best;
    int cnt;
    bit found;
    for (int i = 0; i < 4; i++) begin
      res.lat[i] = LAT_NONE;
      best_lats[i] = 0;
    end
    res.ovf = ovf_seen;
    res.vld = (nhits >= 3);
    res.qual = 24'd0;
    if (nhits < 3) return res;
    for (int j = 0; j < nhits; j++) begin
      dt = hit_tm[j] - pedestal;
      y2[j] = (2 * longint'(hit_lyr[j]) + 1) * longint'(pitch_y);
      xw[j] = (2 * longint'(hit_cell[j]) + (hit_lyr[j][0] ? 1 : 2)) * longint'(width_x);
      onwire[j] = dt < 0;
      d2[j] = 0;
      if (!onwire[j]) begin
        d = (dt * longint'(vdrift)) >>> 7;
        d2[j] = (d < longint'(width_x)) ? d : longint'(width_x);
      end
    end
    found = 0;
    best = 0;
    for (int c = 0; c < (1 << nhits); c++) begin
      for (int i = 0; i < 4; i++) lats[i] = 0;
      for (int j = 0; j < nhits; j++) begin
        if (onwire[j]) begin
          x[j] = xw[j];
          lats[hit_lyr[j]] = 0;
        end else if ((c >> j) & 1) begin
          x[j] = xw[j] + d2[j];
          lats[hit_lyr[j]] = 1;
        end else begin
          x[j] = xw[j] - d2[j];
          lats[hit_lyr[j]] = -1;
        end
      end
      cnt = 0;
      sum = 0;
      for (int j = 0; j < nhits; j++)
        for (int k = j + 1; k < nhits; k++) begin
          dy = y2[j] - y2[k];
          if (dy != 0) begin
            v = ((x[j] - x[k]) * 65536) / dy;
            if (v > 536870912) v = 536870912;
            if (v < -536870912) v = -536870912;
            s[cnt] = v;
            cnt++;
            sum += v;
          end
        end
      if (cnt >= 2) begin
        mean = sum / cnt;
        sq = 0;
        for (int m = 0; m < cnt; m++) begin
          dv = s[m] - mean;
          if (dv < 0) dv = -dv;
          sq += longint'(dv) * longint'(dv);
        end
        sd = int_sqrt(sq / longint'(cnt - 1));
        if (!found || sd < best) begin
          found = 1;
          best = sd;
          best_lats = lats;
        end
      end
    end
    // no eligible combination leaves lateralities at none
    res.qual = (!found || best > 64'hFF_FFFF) ? QUAL_MAX : best[23:0];
    for (int i = 0; i < 4; i++) res.lat[i] = 2'(best_lats[i]);
    return res;
  endfunction

  always @(posedge clk) begin
    fit_result_t exp_r;
    logic [1:0]  got [4];
    int          nerr;
    nerr = 0;
    if (rst) begin
      pitch_y  <= 13000;
      width_x  <= 42000;
      pedestal <= 0;
      vdrift   <= 864;
      nhits    = 0;
      ovf_seen = 0;
      fails    <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PITCH:  pitch_y  <= cfg_data;
          CFG_WIDTH:  width_x  <= cfg_data;
          CFG_PED:    pedestal <= longint'(signed'(cfg_data[14:0]));
          CFG_VDRIFT: vdrift   <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (nhits < 4) begin
          hit_lyr[nhits]  = layer;
          hit_cell[nhits] = cell_req;
          hit_tm[nhits]   = longint'(hit_time);
          nhits = nhits + 1;
        end else begin
          ovf_seen = 1;
        end
        if (last) begin
          fit_queue.insert(fit_queue.size(), predict_fit());
          nhits = 0;
          ovf_seen = 0;
        end
      end
      if (out_valid && out_ready) begin
        got[0] = lat_layer0;
        got[1] = lat_layer1;
        got[2] = lat_layer2;
        got[3] = lat_layer3;
        if (fit_queue.size() == 0) begin
          $error("result item with no cluster pending");
          nerr++;
        end else begin
          exp_r = fit_queue.pop_front();
          for (int i = 0; i < 4; i++)
            if (got[i] !== exp_r.lat[i]) begin
              $error("lat_layer%0d expected %0d got %0d", i,
                     signed'(exp_r.lat[i]), signed'(got[i]));
              nerr++;
            end
          if (quality !== exp_r.qual) begin
            $error("quality expected %0d got %0d", exp_r.qual, quality);
            nerr++;
          end
          if (valid_res !== exp_r.vld) begin
            $error("valid_res expected %0d got %0d", exp_r.vld, valid_res);
            nerr++;
          end
          if (overflow !== exp_r.ovf) begin
            $error("overflow expected %0d got %0d", exp_r.ovf, overflow);
            nerr++;
          end
        end
      end
      fails <= fails + nerr;
    end
  end
endmodule

/* sim/tb_drift_tube_laterality_fit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drift_tube_laterality_fit
// sends hit clusters under several configurations and idling patterns; the
// checker predicts and compares each cluster result
// ----------------------------------------------------------------------------
module tb_drift_tube_laterality_fit;
  import dtlf_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_write = 0;
  logic [1:0]         cfg_index = CFG_PITCH;
  logic [15:0]        cfg_data = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         layer = 0;
  logic [3:0]         cell_req = 0;
  logic signed [14:0] hit_time = 0;
  logic               last = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [1:0]  lat_layer0, lat_layer1, lat_layer2, lat_layer3;
  logic [23:0]        quality;
  logic               valid_res, overflow;
  int                 fails, pending;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 hits_sent = 0;
  int                 cycles = 0;
  logic signed [14:0] cur_ped = 0;

  always #5 clk = ~clk;

  drift_tube_laterality_fit uut (.*);

  drift_tube_laterality_fit_checker chk (.*);

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[drift_tube_laterality_fit] ERROR");
      $finish;
    end
  end

  task automatic send_hit(input logic [1:0] l, input logic [3:0] c,
                          input logic signed [14:0] t, input logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1;
    layer    <= l;
    cell_req <= c;
    hit_time <= t;
    last     <= lst;
    do @(posedge clk); while (!in_ready);
    hits_sent++;
  endtask

  // wait for every cluster result, then let the fit engine settle
  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] p, input logic [15:0] w,
                            input logic signed [14:0] ped, input logic [11:0] v);
    logic [15:0] vals [4];
    vals[CFG_PITCH] = p;
    vals[CFG_WIDTH] = w;
    vals[CFG_PED] = {ped[14], ped};
    vals[CFG_VDRIFT] = {4'd0, v};
    cur_ped = ped;
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [14:0] pick_time();
    int t;
    if ($urandom_range(99) < 20) return 15'($urandom);
    t = int'(cur_ped) + int'($urandom_range(7100)) - 100;
    if (t > 16383) t = 16383;
    if (t < -16384) t = -16384;
    return 15'(t);
  endfunction

  task automatic random_cluster();
    int n, r;
    logic [1:0] ord [4];
    bit tidy;
    r = $urandom_range(99);
    n = (r < 10) ? $urandom_range(1, 2) : (r < 45) ? 3 : (r < 90) ? 4 : $urandom_range(5, 6);
    tidy = ($urandom_range(99) < 80);
    ord = '{2'd0, 2'd1, 2'd2, 2'd3};
    ord.shuffle();
    for (int i = 0; i < n; i++)
      send_hit(tidy && i < 4 ? ord[i] : 2'($urandom), 4'($urandom), pick_time(),
               i == n - 1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // short clusters, the wire case, extreme cells and times
    send_hit(0, 3, 100, 1);
    send_hit(1, 4, 200, 0);
    send_hit(2, 4, 300, 1);
    send_hit(0, 0, -16384, 0);
    send_hit(1, 15, 16383, 0);
    send_hit(2, 7, -5, 1);
    send_hit(3, 15, 0, 0);
    send_hit(2, 0, 16383, 0);
    send_hit(1, 8, 500, 0);
    send_hit(0, 0, 1000, 1);
    // every hit on one layer gives no slope at all
    send_hit(2, 1, 100, 0);
    send_hit(2, 2, 200, 0);
    send_hit(2, 3, 300, 1);
    // extra hits are dropped
    for (int i = 0; i < 6; i++) send_hit(2'(i), 4'(i * 3), 15'(i * 400), i == 5);
    drain();
    set_config(1, 1, -1024, 0);
    for (int i = 0; i < 4; i++) send_hit(2'(i), 4'(i), 15'(i * 50 - 1030), i == 3);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_config(13000, 42000, 0, 864);
        1: set_config(65535, 65535, 16383, 4095);
        2: set_config(0, 16'($urandom), 15'($urandom_range(2000)), 12'($urandom));
        default: set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                            15'(int'($urandom_range(17407)) - 1024), 12'($urandom));
      endcase
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        3: begin send_idle_pct = 29; stall_pct = 29; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      while (hits_sent < 25 + 120 * (ph + 1)) random_cluster();
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("[drift_tube_laterality_fit] OK");
    end else begin
      $display("[drift_tube_laterality_fit] ERROR");
    end
    $finish;
  end
endmodule
